// ----- hdl/valid_masked_kth_rank_select_top_macros.svh -----
// Assertion macros shared by the rank select block.
`ifndef VALID_MASKED_KTH_RANK_SELECT_TOP_MACROS_SVH
`define VALID_MASKED_KTH_RANK_SELECT_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VMKRS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define VMKRS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// The consequent must hold a fixed number of cycles after the antecedent.
`define VMKRS_ASSERT_DELAY(label, ante, cyc, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##(cyc) (cons)) \
    else $error(msg);

`endif

// ----- hdl/vmkrs_pkg.sv -----
// Types and constants of the valid-masked k-th rank select block.
package vmkrs_pkg;

  localparam int NUM_CONTRASTS      = 8;
  localparam int RANK_W             = 20;
  localparam int PROP_FRACTION_BITS = 16;
  localparam int PROP_W             = PROP_FRACTION_BITS + 1;
  localparam int CNT_W              = $clog2(NUM_CONTRASTS + 1);
  localparam int IDX_W              = (NUM_CONTRASTS > 1) ? $clog2(NUM_CONTRASTS) : 1;
  localparam int PROD_W             = CNT_W + PROP_W;
  localparam int KQ_W               = PROD_W - PROP_FRACTION_BITS;

  localparam logic [PROP_W-1:0] PROP_RESET = PROP_W'(1) << (PROP_FRACTION_BITS - 1);
  localparam logic [PROD_W-1:0] CEIL_BIAS  = (PROD_W'(1) << PROP_FRACTION_BITS) - PROD_W'(1);

  typedef logic [RANK_W-1:0]                 rank_t;
  typedef rank_t [NUM_CONTRASTS-1:0]         rank_vec_t;
  typedef logic [NUM_CONTRASTS-1:0]          lane_mask_t;
  typedef logic [CNT_W-1:0]                  cnt_t;
  typedef logic [PROP_W-1:0]                 prop_t;
  typedef logic [PROD_W-1:0]                 prod_t;
  typedef logic [KQ_W-1:0]                   kq_t;
  typedef logic [IDX_W-1:0]                  idx_t;

  // One gene travelling down the row of insertion cells.
  typedef struct packed {
    logic       valid;
    lane_mask_t mask;    // lanes still to be inserted, lane 0 next
    rank_vec_t  raw;     // ranks still to be inserted, lane 0 next
    rank_vec_t  sorted;  // ascending list built so far
    cnt_t       cnt;     // entries of sorted that are in use
    prod_t      prod;    // n times proportion
  } beat_t;

endpackage

// ----- hdl/vmkrs_cell.sv -----
// Insertion cell: places the next lane's rank into the sorted list of a gene.
module vmkrs_cell (
  input  logic           clk,
  input  logic           rst,
  input  vmkrs_pkg::beat_t beat_in,
  output vmkrs_pkg::beat_t beat_out
);
  import vmkrs_pkg::*;

  lane_mask_t le;
  lane_mask_t le_prev;
  rank_vec_t  sorted_up;
  rank_t      x;
  logic       ins;
  beat_t      beat_next;

  always_comb begin
    x   = beat_in.raw[0];
    ins = beat_in.mask[0];
    // le is a run of ones: entries in use that do not exceed the new rank.
    for (int j = 0; j < NUM_CONTRASTS; j++) begin
      le[j] = (CNT_W'(j) < beat_in.cnt) && (beat_in.sorted[j] <= x);
    end
    le_prev   = (le << 1) | NUM_CONTRASTS'(1);
    sorted_up = beat_in.sorted << RANK_W;

    beat_next      = beat_in;
    beat_next.mask = beat_in.mask >> 1;
    beat_next.raw  = beat_in.raw >> RANK_W;
    beat_next.cnt  = beat_in.cnt + CNT_W'(ins);
    if (ins) begin
      for (int j = 0; j < NUM_CONTRASTS; j++) begin
        if (le[j]) begin
          beat_next.sorted[j] = beat_in.sorted[j];
        end else if (le_prev[j]) begin
          beat_next.sorted[j] = x;
        end else begin
          beat_next.sorted[j] = sorted_up[j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      beat_out <= '0;
    end else begin
      beat_out <= beat_next;
    end
  end

endmodule

// ----- hdl/vmkrs_select.sv -----
// Output stage: forms k from the count and proportion and picks the k-th entry.
module vmkrs_select (
  input  logic                   clk,
  input  logic                   rst,
  input  vmkrs_pkg::beat_t       beat_in,
  output vmkrs_pkg::rank_t       top_rank,
  output logic                   found,
  output logic                   done
);
  import vmkrs_pkg::*;

  prod_t sum;
  kq_t   kq;
  kq_t   kd;
  kq_t   klast;
  kq_t   kclip;
  logic  any;
  rank_t sel;

  always_comb begin
    sum   = beat_in.prod + CEIL_BIAS;
    kq    = sum[PROD_W-1:PROP_FRACTION_BITS];
    kd    = (kq != '0) ? kq - KQ_W'(1) : kq;
    any   = (beat_in.cnt != '0);
    klast = KQ_W'(beat_in.cnt) - KQ_W'(1);
    kclip = (any && (kd > klast)) ? klast : kd;
    sel   = beat_in.sorted[kclip[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    top_rank <= any ? sel : '0;
    found    <= any;
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= beat_in.valid;
    end
  end

endmodule

// ----- hdl/valid_masked_kth_rank_select_top.sv -----
// Top level of the valid-masked k-th smallest rank select block.
// A gene accepted at ingress passes through the row of insertion cells and the select stage,
// which registers its result beat onto the output ports together with done.
// Throughput: one gene per cycle, set by the row of insertion cells, one cell per lane.
// The result receiver cannot stall, so busy stays low and start is always taken.
// Reset (rst, synchronous, active high) empties the pipeline and sets proportion to 0.5.
`include "valid_masked_kth_rank_select_top_macros.svh"

module valid_masked_kth_rank_select_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic                                cfg_we,
  input  logic [vmkrs_pkg::PROP_W-1:0]        cfg_data,
  input  logic [vmkrs_pkg::NUM_CONTRASTS-1:0] valid_mask,
  input  logic [vmkrs_pkg::RANK_W-1:0]        rank_0,
  input  logic [vmkrs_pkg::RANK_W-1:0]        rank_1,
  input  logic [vmkrs_pkg::RANK_W-1:0]        rank_2,
  input  logic [vmkrs_pkg::RANK_W-1:0]        rank_3,
  input  logic [vmkrs_pkg::RANK_W-1:0]        rank_4,
  input  logic [vmkrs_pkg::RANK_W-1:0]        rank_5,
  input  logic [vmkrs_pkg::RANK_W-1:0]        rank_6,
  input  logic [vmkrs_pkg::RANK_W-1:0]        rank_7,
  output logic [vmkrs_pkg::RANK_W-1:0]        top_rank,
  output logic                                found,
  output logic                                done
);
  import vmkrs_pkg::*;

  // The proportion register, unsigned fixed point with 2^16 meaning 1.0.
  prop_t proportion;

  // chain[0] is the ingress register; chain[i+1] is the output of cell i.
  beat_t chain [NUM_CONTRASTS+1];
  beat_t ingress_next;
  cnt_t  n;

  // Every cycle can take a new gene, since each stage hands its beat on unconditionally.
  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      proportion <= PROP_RESET;
    end else if (cfg_we) begin
      proportion <= cfg_data;
    end
  end

  // Ingress stage: count the valid lanes and form n times proportion. The ceiling and
  // the clip to n-1 happen at the far end, once the sorted list is complete.
  always_comb begin
    n = '0;
    for (int i = 0; i < NUM_CONTRASTS; i++) begin
      n = n + CNT_W'(valid_mask[i]);
    end
    ingress_next.valid     = start && !busy;
    ingress_next.mask      = valid_mask;
    ingress_next.raw[0]    = rank_0;
    ingress_next.raw[1]    = rank_1;
    ingress_next.raw[2]    = rank_2;
    ingress_next.raw[3]    = rank_3;
    ingress_next.raw[4]    = rank_4;
    ingress_next.raw[5]    = rank_5;
    ingress_next.raw[6]    = rank_6;
    ingress_next.raw[7]    = rank_7;
    ingress_next.sorted    = '0;
    ingress_next.cnt       = '0;
    ingress_next.prod      = PROD_W'(n) * PROD_W'(proportion);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain[0] <= '0;
    end else begin
      chain[0] <= ingress_next;
    end
  end

  // One insertion cell per lane. Each cell takes the lowest remaining lane and, when
  // its mask bit is set, slots the rank into the ascending list, so the list is
  // complete after the last cell. Equal ranks stay as separate entries.
  for (genvar c = 0; c < NUM_CONTRASTS; c++) begin : g_cell
    vmkrs_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .beat_in  (chain[c]),
      .beat_out (chain[c+1])
    );
  end

  // Final stage: k = ceil(n * prop), decremented when nonzero and clipped to n-1, then the
  // k-th entry, or zero when no lane is valid, is registered onto the result ports with the done strobe.
  vmkrs_select u_select (
    .clk      (clk),
    .rst      (rst),
    .beat_in  (chain[NUM_CONTRASTS]),
    .top_rank (top_rank),
    .found    (found),
    .done     (done)
  );

  // An accepted gene always produces a result beat with done raised.
  `VMKRS_ASSERT_DELAY(a_latency, start && !busy, NUM_CONTRASTS + 2, done, "result beat missing")
  // The completed list is ascending in its first two entries.
  `VMKRS_ASSERT_IMP(a_sorted, chain[NUM_CONTRASTS].valid && (chain[NUM_CONTRASTS].cnt >= CNT_W'(2)), chain[NUM_CONTRASTS].sorted[0] <= chain[NUM_CONTRASTS].sorted[1], "list out of order")
  // A gene with no valid lane comes out as not found with a zero rank.
  `VMKRS_ASSERT_NEXT(a_empty, chain[NUM_CONTRASTS].valid && (chain[NUM_CONTRASTS].cnt == '0), done && !found && (top_rank == '0), "empty gene not flagged")

endmodule

// ----- tb/valid_masked_kth_rank_select_top_tb.sv -----
// Self-checking testbench for the valid-masked k-th smallest rank select block.
`timescale 1ns / 1ps

module valid_masked_kth_rank_select_top_tb;
  import vmkrs_pkg::*;

  // A result beat comes out once its gene has passed the ingress register, every insertion cell and the select stage.
  localparam int LATENCY = NUM_CONTRASTS + 1;
  localparam int PHASE_CHUNKS = 4;
  localparam int CHUNK_GENES = 96;
  localparam rank_t RANK_MAX = '1;
  localparam prop_t PROP_ONE = prop_t'(1) << PROP_FRACTION_BITS;
  localparam prop_t PROP_FULL = '1;

  // What the block should report for one gene.
  typedef struct packed {
    rank_t rank;
    logic  found;
  } rank_pick_t;

  logic       clk;
  logic       rst;
  logic       start;
  logic       busy;
  logic       cfg_we;
  prop_t      cfg_data;
  lane_mask_t valid_mask;
  rank_t      rank_0, rank_1, rank_2, rank_3, rank_4, rank_5, rank_6, rank_7;
  rank_t      top_rank;
  logic       found;
  logic       done;

  // Our own copy of the proportion register, updated on every write.
  prop_t      proportion_shadow;
  // Picks still owed by the block, oldest first.
  rank_pick_t expected_picks[$];
  rank_pick_t oldest_pick;

  int sender_idle_pct;
  int error_count;
  int genes_sent;
  int empty_genes;
  int settings_used;
  int picks_checked;

  valid_masked_kth_rank_select_top dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .valid_mask (valid_mask),
    .rank_0     (rank_0),
    .rank_1     (rank_1),
    .rank_2     (rank_2),
    .rank_3     (rank_3),
    .rank_4     (rank_4),
    .rank_5     (rank_5),
    .rank_6     (rank_6),
    .rank_7     (rank_7),
    .top_rank   (top_rank),
    .found      (found),
    .done       (done)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Works out the k-th smallest valid rank. The lanes that the mask marks are
  // gathered and sorted ascending; ties stay as separate entries. k is the
  // ceiling of n times the proportion, less one when nonzero, and then held
  // to n - 1 so that a proportion above one picks the largest rank.
  function automatic rank_pick_t pick_kth_rank(input lane_mask_t mask,
                                               input rank_vec_t ranks,
                                               input prop_t prop);
    rank_t           ordered [NUM_CONTRASTS];
    rank_t           hold;
    int              n;
    int              i;
    int              j;
    longint unsigned count;
    longint unsigned k;
    rank_pick_t      pick;
    n = 0;
    for (i = 0; i < NUM_CONTRASTS; i++) begin
      if (mask[i]) begin
        ordered[n] = ranks[i];
        n++;
      end
    end
    if (n == 0) begin
      pick.rank = '0;
      pick.found = 1'b0;
      return pick;
    end
    for (i = 1; i < n; i++) begin
      hold = ordered[i];
      j = i;
      while (j > 0 && ordered[j-1] > hold) begin
        ordered[j] = ordered[j-1];
        j--;
      end
      ordered[j] = hold;
    end
    count = n;
    k = (count * prop + ((64'd1 << PROP_FRACTION_BITS) - 64'd1)) >> PROP_FRACTION_BITS;
    if (k != 0) k--;
    if (k > count - 1) k = count - 1;
    pick.rank = ordered[int'(k)];
    pick.found = 1'b1;
    return pick;
  endfunction

  // Prints one line per mismatch and keeps count; the run carries on.
  task automatic report_mismatch(input string what);
    error_count++;
    $display("MISMATCH at %0t ns: %s", $time, what);
  endtask

  // Every done beat is compared against the oldest outstanding pick. The
  // outputs are read at the rising edge, before the block updates them.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_picks.size() == 0) begin
        report_mismatch($sformatf("result beat with no gene outstanding, top_rank %0d found %0b",
                                  top_rank, found));
      end else begin
        oldest_pick = expected_picks.pop_front();
        picks_checked++;
        if (found !== oldest_pick.found)
          report_mismatch($sformatf("found is %b, expected %b", found, oldest_pick.found));
        if (top_rank !== oldest_pick.rank)
          report_mismatch($sformatf("top_rank is %0d, expected %0d",
                                    top_rank, oldest_pick.rank));
      end
    end
  end

  // Sends one gene. It is entered on a falling edge and leaves on one. The
  // sender may first sit idle with start low, as often as sender_idle_pct
  // asks. The gene is taken at the first rising edge where busy is low, and
  // its pick is queued right there with the proportion the block then holds.
  task automatic send_gene(input lane_mask_t mask, input rank_vec_t ranks);
    while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start      <= 1'b1;
    valid_mask <= mask;
    rank_0     <= ranks[0];
    rank_1     <= ranks[1];
    rank_2     <= ranks[2];
    rank_3     <= ranks[3];
    rank_4     <= ranks[4];
    rank_5     <= ranks[5];
    rank_6     <= ranks[6];
    rank_7     <= ranks[7];
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_picks.push_back(pick_kth_rank(mask, ranks, proportion_shadow));
    genes_sent++;
    if (mask == '0) empty_genes++;
    @(negedge clk);
  endtask

  // Lowers start and waits for every outstanding pick, then lets the
  // pipeline drain so that the block is surely empty.
  task automatic settle_pipeline();
    start <= 1'b0;
    do @(negedge clk); while (expected_picks.size() != 0);
    repeat (LATENCY) @(negedge clk);
  endtask

  // Writes the proportion register. Only called with the pipeline empty.
  task automatic write_proportion(input prop_t value);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(negedge clk);
    cfg_we   <= 1'b0;
    proportion_shadow = value;
    settings_used++;
  endtask

  // Picks a proportion for a stretch of random traffic. Most are ordinary
  // fractions, but zero, one step above zero, exactly one, one less than one,
  // and values above one up to the full register width come up regularly.
  function automatic prop_t choose_proportion();
    case ($urandom_range(0, 11))
      0: return '0;
      1: return PROP_ONE;
      2: return prop_t'($urandom_range(int'(PROP_ONE) + 1, int'(PROP_FULL)));
      3: return prop_t'(1);
      4: return PROP_ONE - prop_t'(1);
      default: return prop_t'($urandom_range(0, int'(PROP_ONE)));
    endcase
  endfunction

  // Builds one random gene. Small rank ranges give plenty of ties, and the
  // mask is sometimes empty, full or a single lane.
  task automatic make_random_gene(output lane_mask_t mask, output rank_vec_t ranks);
    int style;
    int i;
    case ($urandom_range(0, 15))
      0: mask = '0;
      1: mask = '1;
      2: mask = lane_mask_t'(1) << $urandom_range(0, NUM_CONTRASTS - 1);
      default: mask = lane_mask_t'($urandom);
    endcase
    style = $urandom_range(0, 9);
    for (i = 0; i < NUM_CONTRASTS; i++) begin
      if (style < 4) ranks[i] = rank_t'($urandom);
      else if (style < 7) ranks[i] = rank_t'($urandom_range(0, 7));
      else if (style == 7) ranks[i] = $urandom_range(0, 1) ? RANK_MAX : '0;
      else ranks[i] = rank_t'($urandom_range(0, 4095));
    end
  endtask

  // Genes at the reset proportion of one half: the empty mask, full masks
  // with extreme ranks, single lanes, descending ranks and equal ranks.
  task automatic test_reset_proportion();
    rank_vec_t ranks;
    int        i;
    send_gene('0, {NUM_CONTRASTS{RANK_MAX}});
    send_gene('1, '0);
    send_gene('1, {NUM_CONTRASTS{RANK_MAX}});
    for (i = 0; i < NUM_CONTRASTS; i++) ranks[i] = RANK_MAX - rank_t'(i * 1000);
    send_gene('1, ranks);
    send_gene(lane_mask_t'(8'h80), {NUM_CONTRASTS{RANK_MAX}});
    for (i = 0; i < NUM_CONTRASTS; i++) ranks[i] = (i == 0) ? '0 : RANK_MAX;
    send_gene(lane_mask_t'(8'h01), ranks);
    for (i = 0; i < NUM_CONTRASTS; i++) ranks[i] = i[0] ? rank_t'(5) : '0;
    send_gene(lane_mask_t'(8'hAA), ranks);
    for (i = 0; i < NUM_CONTRASTS; i++) ranks[i] = rank_t'((i * 7919) % 64);
    send_gene(lane_mask_t'(8'h55), ranks);
  endtask

  // Zero should return the smallest valid rank, one and above should return
  // the largest; values just above zero and just below one sit at the edges
  // of the rounding.
  task automatic test_proportion_extremes();
    prop_t     settings [5];
    rank_vec_t ranks;
    int        s;
    int        i;
    settings = '{'0, PROP_ONE, PROP_FULL, prop_t'(1), PROP_ONE - prop_t'(1)};
    for (s = 0; s < 5; s++) begin
      settle_pipeline();
      write_proportion(settings[s]);
      for (i = 0; i < NUM_CONTRASTS; i++) ranks[i] = rank_t'(((i * 5) % NUM_CONTRASTS) * 300);
      send_gene('1, ranks);
      for (i = 0; i < NUM_CONTRASTS; i++) ranks[i] = rank_t'($urandom);
      send_gene(lane_mask_t'(8'h0F), ranks);
      send_gene(lane_mask_t'(8'hF0), {NUM_CONTRASTS{RANK_MAX}});
    end
  endtask

  // Random genes in three phases: the sender idles often, then very often,
  // then never. Each phase is cut into chunks with their own proportion,
  // written while the pipeline is empty. Now and then the sender holds off
  // until every outstanding pick has come back.
  task automatic test_random_traffic();
    int         idle_per_phase [3];
    int         phase;
    int         chunk;
    int         g;
    lane_mask_t mask;
    rank_vec_t  ranks;
    idle_per_phase = '{27, 74, 0};
    for (phase = 0; phase < 3; phase++) begin
      sender_idle_pct = idle_per_phase[phase];
      for (chunk = 0; chunk < PHASE_CHUNKS; chunk++) begin
        settle_pipeline();
        write_proportion(choose_proportion());
        for (g = 0; g < CHUNK_GENES; g++) begin
          if ($urandom_range(0, 49) == 0) begin
            start <= 1'b0;
            do @(negedge clk); while (expected_picks.size() != 0);
          end
          make_random_gene(mask, ranks);
          send_gene(mask, ranks);
        end
      end
    end
  endtask

  initial begin
    rst               = 1'b1;
    start             = 1'b0;
    cfg_we            = 1'b0;
    cfg_data          = '0;
    valid_mask        = '0;
    rank_0            = '0;
    rank_1            = '0;
    rank_2            = '0;
    rank_3            = '0;
    rank_4            = '0;
    rank_5            = '0;
    rank_6            = '0;
    rank_7            = '0;
    proportion_shadow = PROP_RESET;
    sender_idle_pct   = 0;
    error_count       = 0;
    genes_sent        = 0;
    empty_genes       = 0;
    settings_used     = 1;
    picks_checked     = 0;

    // Reset is held high while the clock runs and is released on a falling edge.
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reset_proportion();
    test_proportion_extremes();
    test_random_traffic();

    // All genes are in; wait for the last picks, then give a stray beat
    // a chance to show up before the verdict.
    settle_pipeline();
    repeat (4) @(negedge clk);

    $display("Sent %0d genes (%0d with no valid rank), checked %0d result beats.",
             genes_sent, empty_genes, picks_checked);
    $display("Proportion took %0d settings, from zero through one to the full register.",
             settings_used);
    if (error_count == 0) begin
      $display("valid_masked_kth_rank_select_top verification clean");
    end else begin
      $display("valid_masked_kth_rank_select_top verification failed");
    end
    $finish;
  end

  // This watchdog fires far past the end of a correct run.
  initial begin
    #2000000;
    $display("Timed out with %0d picks outstanding.", expected_picks.size());
    $display("valid_masked_kth_rank_select_top verification failed");
    $finish;
  end

endmodule
